// File: rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types for the line rasterizer: the item opcode and the flag group
// that passes between the state registers and the step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

   // What an input item asks for.
   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   // Direction and activity flags of the line being drawn.
   typedef struct packed {
      logic x_is_major;
      logic step_x_negative;
      logic step_y_negative;
      logic line_active;
   } flags_type;

endpackage : brl_pkg

`default_nettype wire

// File: rtl/bresenham_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Integer Bresenham line rasterizer giving one result item per input item.
// ----------------------------------------------------------------------------
// A start item (opcode 0) loads both endpoints and returns the start pixel;
// each step item (opcode 1) returns the next pixel along the line, and the
// endpoint pixel carries last_pixel. A step item with no line in progress
// returns an item with pixel_valid low and zero coordinates. A start item
// always abandons any line still being drawn. The block takes one item per
// clock cycle and keeps doing so as long as results are taken: an item is
// captured in an input register, and once the result register is empty or
// being emptied, the step logic, which is one add and compare on the
// registered error term and coordinates, forms the pixel into the result
// register while updating the line state. A result is offered once its item
// has moved from the input register into the result register. When the result
// register is held by a stalled consumer the input register still takes one
// more item, so ready falls only when both stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_top #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input items.
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_opcode,
   input  wire logic [COORD_BITS-1:0]  req_start_x,
   input  wire logic [COORD_BITS-1:0]  req_start_y,
   input  wire logic [COORD_BITS-1:0]  req_end_x,
   input  wire logic [COORD_BITS-1:0]  req_end_y,
   // Result items.
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_pixel_valid,
   output logic      [COORD_BITS-1:0]  rsp_pixel_x,
   output logic      [COORD_BITS-1:0]  rsp_pixel_y,
   output logic                        rsp_last_pixel
);

   localparam int EW = COORD_BITS + 3;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic                  in_opcode_ff;
   logic [COORD_BITS-1:0] in_start_x_ff, in_start_y_ff;
   logic [COORD_BITS-1:0] in_end_x_ff, in_end_y_ff;

   // Line state.
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] delta_major_ff, delta_major_in;
   logic [COORD_BITS-1:0] delta_minor_ff, delta_minor_in;
   logic [EW-1:0]         error_term_ff, error_term_in;
   logic [COORD_BITS-1:0] steps_left_ff, steps_left_in;
   brl_pkg::flags_type    flags_ff, flags_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  px_valid_ff, px_valid_in;
   logic [COORD_BITS-1:0] px_x_ff, px_x_in;
   logic [COORD_BITS-1:0] px_y_ff, px_y_in;
   logic                  px_last_ff, px_last_in;

   logic req_take;
   logic advance;

   // The item in the input register moves on whenever the result register is
   // empty or is being emptied in this cycle.
   always_comb begin
      advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      req_take     = req_valid && req_ready;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   brl_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .opcode           (brl_pkg::opcode_type'(in_opcode_ff)),
      .start_x          (in_start_x_ff),
      .start_y          (in_start_y_ff),
      .end_x            (in_end_x_ff),
      .end_y            (in_end_y_ff),
      .cur_x            (cur_x_ff),
      .cur_y            (cur_y_ff),
      .delta_major      (delta_major_ff),
      .delta_minor      (delta_minor_ff),
      .error_term       (error_term_ff),
      .steps_left       (steps_left_ff),
      .flags            (flags_ff),
      .cur_x_next       (cur_x_in),
      .cur_y_next       (cur_y_in),
      .delta_major_next (delta_major_in),
      .delta_minor_next (delta_minor_in),
      .error_term_next  (error_term_in),
      .steps_left_next  (steps_left_in),
      .flags_next       (flags_in),
      .pixel_valid      (px_valid_in),
      .pixel_x          (px_x_in),
      .pixel_y          (px_y_in),
      .last_pixel       (px_last_in)
   );

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input payload is captured on acceptance and needs no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff  <= req_opcode;
         in_start_x_ff <= req_start_x;
         in_start_y_ff <= req_start_y;
         in_end_x_ff   <= req_end_x;
         in_end_y_ff   <= req_end_y;
      end
   end

   // The line state changes only as an item passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         delta_major_ff <= '0;
         delta_minor_ff <= '0;
         error_term_ff  <= '0;
         steps_left_ff  <= '0;
         flags_ff       <= '0;
      end else if (advance) begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         delta_major_ff <= delta_major_in;
         delta_minor_ff <= delta_minor_in;
         error_term_ff  <= error_term_in;
         steps_left_ff  <= steps_left_in;
         flags_ff       <= flags_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         px_valid_ff <= px_valid_in;
         px_x_ff     <= px_x_in;
         px_y_ff     <= px_y_in;
         px_last_ff  <= px_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_valid = px_valid_ff;
   assign rsp_pixel_x     = px_x_ff;
   assign rsp_pixel_y     = px_y_ff;
   assign rsp_last_pixel  = px_last_ff;

endmodule : bresenham_line_rasterizer_top

`default_nettype wire

// File: rtl/brl_step.sv
// ----------------------------------------------------------------------------
// brl_step
// Combinational line step: sets up a new line from its endpoints, or advances
// the current line by one pixel, and forms the pixel that results.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_step #(
   parameter int COORD_BITS = 12
) (
   input  wire brl_pkg::opcode_type      opcode,
   input  wire logic [COORD_BITS-1:0]    start_x,
   input  wire logic [COORD_BITS-1:0]    start_y,
   input  wire logic [COORD_BITS-1:0]    end_x,
   input  wire logic [COORD_BITS-1:0]    end_y,
   // Current line state.
   input  wire logic [COORD_BITS-1:0]    cur_x,
   input  wire logic [COORD_BITS-1:0]    cur_y,
   input  wire logic [COORD_BITS-1:0]    delta_major,
   input  wire logic [COORD_BITS-1:0]    delta_minor,
   input  wire logic [COORD_BITS+2:0]    error_term,
   input  wire logic [COORD_BITS-1:0]    steps_left,
   input  wire brl_pkg::flags_type       flags,
   // Line state after this item.
   output logic      [COORD_BITS-1:0]    cur_x_next,
   output logic      [COORD_BITS-1:0]    cur_y_next,
   output logic      [COORD_BITS-1:0]    delta_major_next,
   output logic      [COORD_BITS-1:0]    delta_minor_next,
   output logic      [COORD_BITS+2:0]    error_term_next,
   output logic      [COORD_BITS-1:0]    steps_left_next,
   output brl_pkg::flags_type            flags_next,
   // Pixel for this item.
   output logic                          pixel_valid,
   output logic      [COORD_BITS-1:0]    pixel_x,
   output logic      [COORD_BITS-1:0]    pixel_y,
   output logic                          last_pixel
);

   localparam int EW = COORD_BITS + 3;

   logic                  x_neg;
   logic                  y_neg;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  x_major;
   logic [COORD_BITS-1:0] maj;
   logic [COORD_BITS-1:0] mnr;
   logic                  err_neg;
   logic                  move_x;
   logic                  move_y;
   logic [COORD_BITS-1:0] nx;
   logic [COORD_BITS-1:0] ny;

   // Set-up of a new line: absolute deltas and the choice of major axis.
   always_comb begin
      x_neg   = end_x <= start_x;
      y_neg   = end_y <= start_y;
      adx     = x_neg ? start_x - end_x : end_x - start_x;
      ady     = y_neg ? start_y - end_y : end_y - start_y;
      x_major = adx > ady;
      maj     = x_major ? adx : ady;
      mnr     = x_major ? ady : adx;
   end

   // One step: the major axis always moves, the minor one when the error is
   // not negative.
   always_comb begin
      err_neg = error_term[EW-1];
      move_x  = flags.x_is_major || !err_neg;
      move_y  = !flags.x_is_major || !err_neg;
      nx = cur_x;
      ny = cur_y;
      if (move_x) begin
         nx = flags.step_x_negative ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
      end
      if (move_y) begin
         ny = flags.step_y_negative ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
      end
   end

   always_comb begin
      cur_x_next       = cur_x;
      cur_y_next       = cur_y;
      delta_major_next = delta_major;
      delta_minor_next = delta_minor;
      error_term_next  = error_term;
      steps_left_next  = steps_left;
      flags_next       = flags;
      pixel_valid      = 1'b0;
      pixel_x          = '0;
      pixel_y          = '0;
      last_pixel       = 1'b0;
      case (opcode)
         brl_pkg::OP_START: begin
            cur_x_next                 = start_x;
            cur_y_next                 = start_y;
            delta_major_next           = maj;
            delta_minor_next           = mnr;
            error_term_next            = EW'({mnr, 1'b0}) - EW'(maj);
            steps_left_next            = maj;
            flags_next.x_is_major      = x_major;
            flags_next.step_x_negative = x_neg;
            flags_next.step_y_negative = y_neg;
            flags_next.line_active     = maj != '0;
            pixel_valid                = 1'b1;
            pixel_x                    = start_x;
            pixel_y                    = start_y;
            last_pixel                 = maj == '0;
         end
         brl_pkg::OP_STEP: begin
            if (flags.line_active) begin
               cur_x_next      = nx;
               cur_y_next      = ny;
               error_term_next = error_term + EW'({delta_minor, 1'b0})
                                 - (err_neg ? EW'(0) : EW'({delta_major, 1'b0}));
               steps_left_next = steps_left - COORD_BITS'(1);
               flags_next.line_active = steps_left != COORD_BITS'(1);
               pixel_valid     = 1'b1;
               pixel_x         = nx;
               pixel_y         = ny;
               last_pixel      = steps_left == COORD_BITS'(1);
            end
         end
         default: begin
            pixel_valid = 1'b0;
         end
      endcase
   end

endmodule : brl_step

`default_nettype wire

// File: dv/bresenham_line_rasterizer_top_test.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_test
// Self-checking bench for the integer Bresenham line rasterizer.
// ----------------------------------------------------------------------------
// A short table of hand-picked items comes first. It covers steps with no line
// in progress, zero-length lines, full-diagonal and axis-aligned lines at the
// coordinate extremes, and a start that drops a line still being drawn. A long
// random run follows. Most of it is whole lines with random endpoints, walked
// pixel by pixel to their end. The rest is long lines that are dropped part
// way, lines that run along the edges of the coordinate space, and loose
// items. Every result item is checked field by field against a behavioural
// model of the line walk, kept inside this bench.
// ----------------------------------------------------------------------------

module bresenham_line_rasterizer_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 12;
   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
   localparam int DIRECTED_ROWS = 27;
   localparam int RANDOM_ITEMS = 1900;

   // One input item, as it is placed on the req_ ports.
   typedef struct packed {
      brl_pkg::opcode_type opcode;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } line_item_type;

   // One result item, as it is seen on the rsp_ ports.
   typedef struct packed {
      logic pixel_valid;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic last_pixel;
   } pixel_type;

   // A row of the directed table. Where has_pixel is set, the pixel is the
   // expected result as written; otherwise the line model supplies it.
   typedef struct packed {
      line_item_type item;
      logic has_pixel;
      pixel_type pixel;
   } directed_row_type;

   localparam pixel_type NO_PIXEL = '0;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_opcode;
   logic [COORD_BITS-1:0] req_start_x;
   logic [COORD_BITS-1:0] req_start_y;
   logic [COORD_BITS-1:0] req_end_x;
   logic [COORD_BITS-1:0] req_end_y;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_pixel_valid;
   logic [COORD_BITS-1:0] rsp_pixel_x;
   logic [COORD_BITS-1:0] rsp_pixel_y;
   logic rsp_last_pixel;

   // State of the line model. It is reset only once, at the start of the run,
   // so the declarations carry the reset values.
   logic [COORD_BITS-1:0] pen_x = '0;
   logic [COORD_BITS-1:0] pen_y = '0;
   int run_major = 0;
   int run_minor = 0;
   int decision = 0;
   int pixels_left = 0;
   bit x_major = 1'b0;
   bit x_down = 1'b0;
   bit y_down = 1'b0;
   bit drawing = 1'b0;

   // Pixels that have been predicted but not yet seen, oldest first.
   pixel_type pending_pixels[$];

   int items_accepted = 0;
   int pixels_seen = 0;
   int fault_count = 0;

   // Set for the closing stretch of the run, in which neither side idles.
   bit quiet_tail = 1'b0;

   directed_row_type directed_table [DIRECTED_ROWS] = '{
      // Steps straight after reset, with the payload at both extremes.
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, 1'b1, NO_PIXEL},
      // A line whose start is its end gives one pixel, flagged as last.
      '{'{brl_pkg::OP_START, 12'd5, 12'd5, 12'd5, 12'd5}, 1'b1,
        '{1'b1, 12'd5, 12'd5, 1'b1}},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, NO_PIXEL},
      // Full diagonal: the tie makes y the major axis.
      '{'{brl_pkg::OP_START, 12'd0, 12'd0, COORD_MAX, COORD_MAX}, 1'b1,
        '{1'b1, 12'd0, 12'd0, 1'b0}},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      // A new start drops the diagonal and walks the other way.
      '{'{brl_pkg::OP_START, COORD_MAX, COORD_MAX, 12'd0, 12'd0}, 1'b1,
        '{1'b1, COORD_MAX, COORD_MAX, 1'b0}},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, 1'b0, NO_PIXEL},
      // Full-width horizontal line.
      '{'{brl_pkg::OP_START, 12'd0, 12'd0, COORD_MAX, 12'd0}, 1'b1,
        '{1'b1, 12'd0, 12'd0, 1'b0}},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      // Shallow x-major line along the top edge, falling by one in y.
      '{'{brl_pkg::OP_START, 12'd0, COORD_MAX, COORD_MAX, 12'd4094}, 1'b1,
        '{1'b1, 12'd0, COORD_MAX, 1'b0}},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      // Short x-major line walked to its end, then one step too many.
      '{'{brl_pkg::OP_START, 12'd10, 12'd20, 12'd13, 12'd21}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, NO_PIXEL},
      // Short y-major line with x moving downwards.
      '{'{brl_pkg::OP_START, 12'd20, 12'd10, 12'd19, 12'd14}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      // Zero-length line in a corner.
      '{'{brl_pkg::OP_START, COORD_MAX, 12'd0, COORD_MAX, 12'd0}, 1'b1,
        '{1'b1, COORD_MAX, 12'd0, 1'b1}},
      // One-pixel vertical drop in the opposite corner.
      '{'{brl_pkg::OP_START, 12'd0, COORD_MAX, 12'd0, 12'd4094}, 1'b1,
        '{1'b1, 12'd0, COORD_MAX, 1'b0}},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, NO_PIXEL},
      '{'{brl_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, NO_PIXEL}
   };

   bresenham_line_rasterizer_top #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_valid(rsp_pixel_valid),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_last_pixel(rsp_last_pixel)
   );

   // 10 ns clock: rising edges at 5, 15, 25 ns and so on.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Walks the line model by one item and returns the pixel it gives. A start
   // item loads the endpoints and sets up the decision term as twice the minor
   // delta less the major delta. A step item moves along the major axis, and
   // also along the minor axis whenever the decision term is not negative.
   function automatic pixel_type trace_pixel(input line_item_type item);
      pixel_type px;
      int dx;
      int dy;
      int adx;
      int ady;
      px = NO_PIXEL;
      if (item.opcode == brl_pkg::OP_START) begin
         dx = int'(item.end_x) - int'(item.start_x);
         dy = int'(item.end_y) - int'(item.start_y);
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         x_down = (dx <= 0);
         y_down = (dy <= 0);
         x_major = (adx > ady);
         run_major = x_major ? adx : ady;
         run_minor = x_major ? ady : adx;
         decision = 2 * run_minor - run_major;
         pixels_left = run_major;
         pen_x = item.start_x;
         pen_y = item.start_y;
         drawing = (pixels_left != 0);
      end else if (drawing) begin
         if (x_major || decision >= 0) begin
            pen_x = x_down ? pen_x - 1'b1 : pen_x + 1'b1;
         end
         if (!x_major || decision >= 0) begin
            pen_y = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
         end
         if (decision >= 0) begin
            decision += 2 * run_minor - 2 * run_major;
         end else begin
            decision += 2 * run_minor;
         end
         pixels_left--;
         drawing = (pixels_left != 0);
      end else begin
         // A step with nothing to draw gives an empty pixel, state untouched.
         return px;
      end
      px.pixel_valid = 1'b1;
      px.pixel_x = pen_x;
      px.pixel_y = pen_y;
      px.last_pixel = !drawing;
      return px;
   endfunction

   // A point no further than spread from c on each axis, kept inside the
   // coordinate space. A spread of the full range gives any point at all.
   function automatic logic [COORD_BITS-1:0] pick_near(input logic [COORD_BITS-1:0] c,
                                                       input int spread);
      int lo;
      int hi;
      lo = int'(c) - spread;
      hi = int'(c) + spread;
      if (lo < 0) begin
         lo = 0;
      end
      if (hi > int'(COORD_MAX)) begin
         hi = int'(COORD_MAX);
      end
      return COORD_BITS'($urandom_range(hi, lo));
   endfunction

   function automatic line_item_type random_item(input brl_pkg::opcode_type opcode);
      line_item_type item;
      item.opcode = opcode;
      item.start_x = COORD_BITS'($urandom_range(0, int'(COORD_MAX)));
      item.start_y = COORD_BITS'($urandom_range(0, int'(COORD_MAX)));
      item.end_x = COORD_BITS'($urandom_range(0, int'(COORD_MAX)));
      item.end_y = COORD_BITS'($urandom_range(0, int'(COORD_MAX)));
      return item;
   endfunction

   task automatic report_fault(input string msg);
      $display("%0t ns: %s", $time, msg);
      fault_count++;
   endtask

   // Offers one item on the request side and waits until it is taken. The
   // model is advanced at the very edge where the item is accepted, so the
   // expected pixel is queued well before the block can return it. Entered and
   // left just after a falling edge.
   task automatic send_item(input line_item_type item, input logic has_pixel,
                            input pixel_type written_pixel);
      pixel_type predicted;
      bit taken;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= item.opcode;
      req_start_x <= item.start_x;
      req_start_y <= item.start_y;
      req_end_x <= item.end_x;
      req_end_y <= item.end_y;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
         if (taken) begin
            predicted = trace_pixel(item);
            pending_pixels.push_back(has_pixel ? written_pixel : predicted);
            items_accepted++;
         end
         @(negedge clock);
      end
   endtask

   // Starts a line that ends within spread of its start, then steps along it
   // for at most walk_limit pixels. A line that is walked to its end is now
   // and then followed by one step too many. With hug_edge the line starts in
   // a corner of the coordinate space.
   task automatic draw_line(input int spread, input int walk_limit, input bit hug_edge);
      line_item_type item;
      int walked;
      item = random_item(brl_pkg::OP_START);
      if (hug_edge) begin
         item.start_x = $urandom_range(0, 1) ? COORD_MAX : '0;
         item.start_y = $urandom_range(0, 1) ? COORD_MAX : '0;
      end
      item.end_x = pick_near(item.start_x, spread);
      item.end_y = pick_near(item.start_y, spread);
      send_item(item, 1'b0, NO_PIXEL);
      walked = 0;
      while (drawing && walked < walk_limit) begin
         send_item(random_item(brl_pkg::OP_STEP), 1'b0, NO_PIXEL);
         walked++;
      end
      if (!drawing && $urandom_range(0, 3) == 0) begin
         send_item(random_item(brl_pkg::OP_STEP), 1'b0, NO_PIXEL);
      end
   endtask

   // Result side: the consumer holds off in short random bursts, with long
   // stretches of steady acceptance in between, and not at all near the end.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Every result item taken is matched against the oldest pending pixel.
   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_fault($sformatf("pixel %0d arrived with nothing outstanding",
                                   pixels_seen));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_valid !== want.pixel_valid) begin
               report_fault($sformatf("pixel %0d: pixel_valid is %b, expected %b",
                                      pixels_seen, rsp_pixel_valid, want.pixel_valid));
            end
            if (rsp_pixel_x !== want.pixel_x) begin
               report_fault($sformatf("pixel %0d: pixel_x is %0d, expected %0d",
                                      pixels_seen, rsp_pixel_x, want.pixel_x));
            end
            if (rsp_pixel_y !== want.pixel_y) begin
               report_fault($sformatf("pixel %0d: pixel_y is %0d, expected %0d",
                                      pixels_seen, rsp_pixel_y, want.pixel_y));
            end
            if (rsp_last_pixel !== want.last_pixel) begin
               report_fault($sformatf("pixel %0d: last_pixel is %b, expected %b",
                                      pixels_seen, rsp_last_pixel, want.last_pixel));
            end
         end
         pixels_seen++;
      end
   end

   // Main sequence: reset, the directed table, the random run, then the drain.
   initial begin : stimulus
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = brl_pkg::OP_START;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_item(directed_table[row].item, directed_table[row].has_pixel,
                   directed_table[row].pixel);
      end

      // Mostly whole short lines, which take the decision term through both
      // of its branches in every octant. Medium lines give longer runs of the
      // same branch. Long random lines are dropped part way, since walking
      // them out would take thousands of items. Corner lines keep the
      // coordinates at their extremes, and loose items mix random starts and
      // steps.
      while (items_accepted < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (items_accepted > DIRECTED_ROWS + RANDOM_ITEMS * 85 / 100) begin
            quiet_tail = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            draw_line(12, 1 << 30, 1'b0);
         end else if (pick < 70) begin
            draw_line(80, 1 << 30, 1'b0);
         end else if (pick < 82) begin
            draw_line(int'(COORD_MAX), $urandom_range(0, 40), 1'b0);
         end else if (pick < 90) begin
            draw_line(40, $urandom_range(0, 60), 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(random_item(brl_pkg::opcode_type'($urandom_range(0, 1))), 1'b0,
                         NO_PIXEL);
            end
         end
      end
      req_valid <= 1'b0;

      // Wait for every pixel still owed, then keep watching in case the block has
      // anything else to say.
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Safety net: the run needs roughly 300 us even at its slowest, so this
   // only fires if the block stops moving.
   initial begin
      #(3_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
rtl/brl_pkg.sv
rtl/brl_step.sv
rtl/bresenham_line_rasterizer_top.sv
dv/bresenham_line_rasterizer_top_test.sv
